/* sv/erc_pkg.sv */
// shared types, constants and codes for the ethernet ipv4 receive classifier
package erc_pkg;

    localparam int RX_BUFFER_BYTES = 512;
    localparam int MAX_FRAME_BYTES = 2048;

    localparam int IDX_W = $clog2(RX_BUFFER_BYTES);
    localparam int CNT_W = $clog2(RX_BUFFER_BYTES + 1);
    localparam int OFF_W = $clog2(MAX_FRAME_BYTES + 1);

    localparam int ETH_HDR = 14;
    localparam int IP_HDR  = 20;
    localparam int UDP_HDR = 8;

    localparam int OFS_ETYPE_HI = 12;
    localparam int OFS_ETYPE_LO = 13;
    localparam int OFS_PROTO    = 23;
    localparam int OFS_ICMP_KIND = 34;
    localparam int OFS_UDP_PORT_HI = 36;
    localparam int OFS_UDP_PORT_LO = 37;
    localparam int OFS_UDP_LEN_HI  = 38;
    localparam int OFS_UDP_LEN_LO  = 39;
    localparam int OFS_ICMP_ID_HI  = 38;
    localparam int OFS_ICMP_ID_LO  = 39;
    localparam int OFS_ICMP_SEQ_HI = 40;
    localparam int OFS_ICMP_SEQ_LO = 41;
    localparam int OFS_PAYLOAD = ETH_HDR + IP_HDR + UDP_HDR;
    localparam int OFS_MATCH   = OFS_PAYLOAD - 1;

    localparam logic [15:0] ETYPE_ARP  = 16'h0806;
    localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_ICMP = 8'd1;
    localparam logic [7:0]  PROTO_TCP  = 8'd6;
    localparam logic [7:0]  PROTO_UDP  = 8'd17;
    localparam logic [7:0]  ICMP_ECHO_REPLY = 8'd0;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_LISTEN_PORT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ECHO_IDENT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ECHO_SEQUENCE = 2'd2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        CLS_RUNT        = 3'd0,
        CLS_ARP         = 3'd1,
        CLS_ECHO_REPLY  = 3'd2,
        CLS_TCP         = 3'd3,
        CLS_UDP         = 3'd4,
        CLS_OTHER_IPV4  = 3'd5,
        CLS_OTHER_ETYPE = 3'd6
    } t_frame_class;

    typedef struct packed {
        logic [15:0] listen_port;
        logic [15:0] echo_ident;
        logic [15:0] echo_sequence;
    } t_cfg;

    typedef struct packed {
        logic             payload_valid;
        logic [7:0]       payload_byte;
        logic [IDX_W-1:0] payload_index;
        logic             frame_done;
        t_frame_class     frame_class;
        logic [CNT_W-1:0] delivered_count;
    } t_result;

endpackage

/* sv/erc_front.sv */
// front end: byte offset tracking, header latching, matching and classification
module erc_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [7:0]           i_byte,
    input  logic                 i_last,
    input  erc_pkg::t_cfg        i_cfg,
    output erc_pkg::t_result     o_result
);

    logic [erc_pkg::OFF_W-1:0] r_offset, n_offset;
    logic [15:0]               r_ether_type, n_ether_type;
    logic [7:0]                r_ip_protocol, n_ip_protocol;
    logic [7:0]                r_icmp_kind, n_icmp_kind;
    logic [15:0]               r_port_or_ident, n_port_or_ident;
    logic [15:0]               r_len_or_seq, n_len_or_seq;
    logic [erc_pkg::CNT_W-1:0] r_payload_limit, n_payload_limit;
    logic [erc_pkg::CNT_W-1:0] r_copied, n_copied;
    logic                      r_match, n_match;

    logic        is_ip;
    logic        is_udp;
    logic        is_icmp;
    logic        deliver;
    logic [15:0] udp_data_len;
    erc_pkg::t_frame_class frame_class;

    assign is_ip   = (r_ether_type == erc_pkg::ETYPE_IPV4);
    assign is_udp  = is_ip && (r_ip_protocol == erc_pkg::PROTO_UDP);
    assign is_icmp = is_ip && (r_ip_protocol == erc_pkg::PROTO_ICMP);
    assign udp_data_len = r_len_or_seq - 16'(erc_pkg::UDP_HDR);

    always_comb begin
        n_ether_type    = r_ether_type;
        n_ip_protocol   = r_ip_protocol;
        n_icmp_kind     = r_icmp_kind;
        n_port_or_ident = r_port_or_ident;
        n_len_or_seq    = r_len_or_seq;
        n_payload_limit = r_payload_limit;
        n_match         = r_match;

        if (r_offset == erc_pkg::OFF_W'(erc_pkg::OFS_ETYPE_HI)) begin
            n_ether_type = {i_byte, 8'h00};
        end else if (r_offset == erc_pkg::OFF_W'(erc_pkg::OFS_ETYPE_LO)) begin
            n_ether_type = {r_ether_type[15:8], i_byte};
        end else if (r_offset == erc_pkg::OFF_W'(erc_pkg::OFS_PROTO)) begin
            n_ip_protocol = i_byte;
        end else if (r_offset == erc_pkg::OFF_W'(erc_pkg::OFS_ICMP_KIND)) begin
            n_icmp_kind = i_byte;
        end else if (is_udp) begin
            if (r_offset == erc_pkg::OFF_W'(erc_pkg::OFS_UDP_PORT_HI)) begin
                n_port_or_ident = {i_byte, 8'h00};
            end else if (r_offset == erc_pkg::OFF_W'(erc_pkg::OFS_UDP_PORT_LO)) begin
                n_port_or_ident = {r_port_or_ident[15:8], i_byte};
            end else if (r_offset == erc_pkg::OFF_W'(erc_pkg::OFS_UDP_LEN_HI)) begin
                n_len_or_seq = {i_byte, 8'h00};
            end else if (r_offset == erc_pkg::OFF_W'(erc_pkg::OFS_UDP_LEN_LO)) begin
                n_len_or_seq = {r_len_or_seq[15:8], i_byte};
            end
        end else if (is_icmp) begin
            if (r_offset == erc_pkg::OFF_W'(erc_pkg::OFS_ICMP_ID_HI)) begin
                n_port_or_ident = {i_byte, 8'h00};
            end else if (r_offset == erc_pkg::OFF_W'(erc_pkg::OFS_ICMP_ID_LO)) begin
                n_port_or_ident = {r_port_or_ident[15:8], i_byte};
            end else if (r_offset == erc_pkg::OFF_W'(erc_pkg::OFS_ICMP_SEQ_HI)) begin
                n_len_or_seq = {i_byte, 8'h00};
            end else if (r_offset == erc_pkg::OFF_W'(erc_pkg::OFS_ICMP_SEQ_LO)) begin
                n_len_or_seq = {r_len_or_seq[15:8], i_byte};
            end
        end

        // header decision on the last header byte
        if (r_offset == erc_pkg::OFF_W'(erc_pkg::OFS_MATCH)) begin
            if (is_udp) begin
                n_match = (i_cfg.listen_port != 16'd0)
                          && (n_port_or_ident == i_cfg.listen_port);
                if (!n_match) begin
                    n_payload_limit = '0;
                end else if (udp_data_len > 16'(erc_pkg::RX_BUFFER_BYTES)) begin
                    n_payload_limit = erc_pkg::CNT_W'(erc_pkg::RX_BUFFER_BYTES);
                end else begin
                    n_payload_limit = udp_data_len[erc_pkg::CNT_W-1:0];
                end
            end else if (is_icmp) begin
                n_match = (n_icmp_kind == erc_pkg::ICMP_ECHO_REPLY)
                          && (n_port_or_ident == i_cfg.echo_ident)
                          && (n_len_or_seq == i_cfg.echo_sequence);
            end
        end
    end

    assign deliver = (r_offset >= erc_pkg::OFF_W'(erc_pkg::OFS_PAYLOAD))
                     && (r_offset < erc_pkg::OFF_W'(erc_pkg::MAX_FRAME_BYTES))
                     && is_udp && r_match && (r_copied < r_payload_limit);

    assign n_copied = deliver ? r_copied + 1'b1 : r_copied;
    assign n_offset = (r_offset < erc_pkg::OFF_W'(erc_pkg::MAX_FRAME_BYTES))
                      ? r_offset + 1'b1 : r_offset;

    always_comb begin
        priority if (r_offset < erc_pkg::OFF_W'(erc_pkg::ETH_HDR - 1)) begin
            frame_class = erc_pkg::CLS_RUNT;
        end else if (n_ether_type == erc_pkg::ETYPE_ARP) begin
            frame_class = erc_pkg::CLS_ARP;
        end else if (n_ether_type != erc_pkg::ETYPE_IPV4) begin
            frame_class = erc_pkg::CLS_OTHER_ETYPE;
        end else if (r_offset < erc_pkg::OFF_W'(erc_pkg::ETH_HDR + erc_pkg::IP_HDR - 1)) begin
            frame_class = erc_pkg::CLS_RUNT;
        end else if (n_ip_protocol == erc_pkg::PROTO_ICMP && n_match) begin
            frame_class = erc_pkg::CLS_ECHO_REPLY;
        end else if (n_ip_protocol == erc_pkg::PROTO_TCP) begin
            frame_class = erc_pkg::CLS_TCP;
        end else if (n_ip_protocol == erc_pkg::PROTO_UDP && n_match) begin
            frame_class = erc_pkg::CLS_UDP;
        end else begin
            frame_class = erc_pkg::CLS_OTHER_IPV4;
        end
    end

    always_comb begin
        o_result.payload_valid   = deliver;
        o_result.payload_byte    = deliver ? i_byte : 8'd0;
        o_result.payload_index   = deliver ? r_copied[erc_pkg::IDX_W-1:0] : '0;
        o_result.frame_done      = i_last;
        o_result.frame_class     = i_last ? frame_class : erc_pkg::CLS_RUNT;
        o_result.delivered_count = i_last ? n_copied : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_last)) begin
            r_offset        <= '0;
            r_ether_type    <= '0;
            r_ip_protocol   <= '0;
            r_icmp_kind     <= '0;
            r_port_or_ident <= '0;
            r_len_or_seq    <= '0;
            r_payload_limit <= '0;
            r_copied        <= '0;
            r_match         <= 1'b0;
        end else if (i_accept) begin
            r_offset        <= n_offset;
            r_ether_type    <= n_ether_type;
            r_ip_protocol   <= n_ip_protocol;
            r_icmp_kind     <= n_icmp_kind;
            r_port_or_ident <= n_port_or_ident;
            r_len_or_seq    <= n_len_or_seq;
            r_payload_limit <= n_payload_limit;
            r_copied        <= n_copied;
            r_match         <= n_match;
        end
    end

endmodule

/* sv/erc_queue.sv */
// result queue between the classifier front end and the result port
module erc_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  erc_pkg::t_result     i_data,
    output logic                 o_full,
    input  logic                 i_pop,
    output logic                 o_empty,
    output erc_pkg::t_result     o_data
);

    erc_pkg::t_result r_mem [erc_pkg::QUEUE_DEPTH];

    logic [erc_pkg::QPTR_W-1:0] r_wr_ptr;
    logic [erc_pkg::QPTR_W-1:0] r_rd_ptr;
    logic [erc_pkg::QPTR_W:0]   r_count;
    logic                       do_push;
    logic                       do_pop;

    assign o_full  = (r_count == (erc_pkg::QPTR_W + 1)'(erc_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* sv/ethernet_ipv4_rx_classifier.sv */
// top level of the ethernet ipv4 receive classifier
//
// channel   direction  handshake            request contents
// input     in         i_push / o_full      frame_byte, last_byte
// result    out        o_empty / i_pop      payload and frame report fields
// config    in         i_cfg_valid / ready  register index, 16-bit data
//
// one request per cycle while the queue is not full; its result enters the result queue at the same edge
// a result can be taken in the cycle after its request is accepted
// the four-entry result queue sets full, so input stalls only when four are unread
// reset clears the frame state, the registers and the queue
module ethernet_ipv4_rx_classifier (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    output logic                          o_full,
    input  logic [7:0]                    i_frame_byte,
    input  logic                          i_last_byte,
    output logic                          o_empty,
    input  logic                          i_pop,
    output logic                          o_payload_valid,
    output logic [7:0]                    o_payload_byte,
    output logic [erc_pkg::IDX_W-1:0]     o_payload_index,
    output logic                          o_frame_done,
    output logic [2:0]                    o_frame_class,
    output logic [erc_pkg::CNT_W-1:0]     o_delivered_count,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [erc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]                   i_cfg_data
);

    erc_pkg::t_cfg    r_cfg;
    erc_pkg::t_result front_result;
    erc_pkg::t_result queue_head;
    logic             in_accept;

    assign o_cfg_ready = 1'b1;
    assign in_accept   = i_push && !o_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                erc_pkg::CFG_LISTEN_PORT:   r_cfg.listen_port   <= i_cfg_data;
                erc_pkg::CFG_ECHO_IDENT:    r_cfg.echo_ident    <= i_cfg_data;
                erc_pkg::CFG_ECHO_SEQUENCE: r_cfg.echo_sequence <= i_cfg_data;
                default: ;
            endcase
        end
    end

    erc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_byte   (i_frame_byte),
        .i_last   (i_last_byte),
        .i_cfg    (r_cfg),
        .o_result (front_result)
    );

    erc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (front_result),
        .o_full  (o_full),
        .i_pop   (i_pop),
        .o_empty (o_empty),
        .o_data  (queue_head)
    );

    assign o_payload_valid   = queue_head.payload_valid;
    assign o_payload_byte    = queue_head.payload_byte;
    assign o_payload_index   = queue_head.payload_index;
    assign o_frame_done      = queue_head.frame_done;
    assign o_frame_class     = queue_head.frame_class;
    assign o_delivered_count = queue_head.delivered_count;

    a_full_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !o_empty)
        else $error("queue full while empty");

    a_push_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> !o_empty)
        else $error("accepted request left no result");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_frame_done)
        |-> (o_delivered_count <= erc_pkg::CNT_W'(erc_pkg::RX_BUFFER_BYTES)))
        else $error("delivered count beyond buffer size");

    a_payload_only_when_matched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && front_result.payload_valid && i_last_byte)
        |-> (front_result.frame_class == erc_pkg::CLS_UDP))
        else $error("payload delivered in a frame not classed as udp");

endmodule
